>>> hdl/conv_bn_prelu_fixed_point_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the conv/bn/prelu block
// Shared property wrappers used by the RTL assertions.
// ----------------------------------------------------------------------------
`ifndef CONV_BN_PRELU_FIXED_POINT_MACROS_SVH
`define CONV_BN_PRELU_FIXED_POINT_MACROS_SVH

// implication checked on every clock edge outside reset
`define CBP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define CBP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> hdl/cbp_pkg.sv
// ----------------------------------------------------------------------------
// cbp_pkg
// Types, constants and arithmetic helpers of the conv/bn/prelu block.
// ----------------------------------------------------------------------------
package cbp_pkg;

  localparam int RowWidth  = 129;
  localparam int Channels  = 12;
  localparam int Taps      = 3;
  localparam int Kinds     = 8;
  localparam int ChW       = 4;
  localparam int PosW      = 7;
  localparam int RowPosW   = 8;
  localparam int TapAddrW  = $clog2(Channels * Taps);
  localparam int ChanAddrW = $clog2(Channels * Kinds);

  localparam logic [3:0] KindTapMax   = 4'd2;
  localparam logic [3:0] KindLast     = 4'd10;
  localparam logic       ActLoad      = 1'b0;
  localparam logic       CfgConvShift = 1'b0;
  localparam logic       CfgNormShift = 1'b1;

  // datapath step codes
  typedef enum logic [3:0] {
    OP_TAP0  = 4'd0,
    OP_TAP1  = 4'd1,
    OP_TAP2  = 4'd2,
    OP_CONV  = 4'd3,
    OP_NORM  = 4'd4,
    OP_NWRAP = 4'd5,
    OP_GAIN  = 4'd6,
    OP_ACT   = 4'd7,
    OP_AFF   = 4'd8,
    OP_OUT   = 4'd9,
    OP_IDLE  = 4'd10
  } op_e;

  typedef struct packed {
    logic           start;   // latch window for a new output position
    op_e            op;
    logic [ChW-1:0] ch;
  } cmd_t;

  typedef struct packed {
    logic done;              // channel value ready for output
  } sts_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [65:0] rshift(input logic signed [65:0] v,
                                                input logic [4:0] s);
    logic signed [65:0] r;
    r = v;
    if (s != 5'd0) r = (v + (66'sd1 <<< (s - 5'd1))) >>> s;
    return r;
  endfunction

endpackage

>>> hdl/cbp_stream_if.sv
// ----------------------------------------------------------------------------
// cbp_in_if / cbp_out_if
// Valid/ready channels of the conv/bn/prelu block.
// ----------------------------------------------------------------------------
interface cbp_in_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic [3:0]         param_kind;
  logic [3:0]         channel_index;
  logic signed [31:0] data_value;
  modport source (output valid, action, param_kind, channel_index, data_value,
                  input ready);
  modport sink (input valid, action, param_kind, channel_index, data_value,
                output ready);
endinterface

interface cbp_out_if;
  logic               valid;
  logic               ready;
  logic [3:0]         out_channel;
  logic [6:0]         out_position;
  logic signed [31:0] out_value;
  logic               last_of_run;
  modport source (output valid, out_channel, out_position, out_value, last_of_run,
                  input ready);
  modport sink (input valid, out_channel, out_position, out_value, last_of_run,
                output ready);
endinterface

>>> hdl/cbp_datapath.sv
// ----------------------------------------------------------------------------
// cbp_datapath
// Parameter tables, a shared multiply/round unit and a separate var multiplier, stepped per channel.
// ----------------------------------------------------------------------------
module cbp_datapath import cbp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 ld_i,
  input  logic [3:0]           kind_i,
  input  logic [ChW-1:0]       ld_ch_i,
  input  logic signed [31:0]   ld_val_i,
  input  logic signed [31:0]   x0_i,
  input  logic signed [31:0]   x1_i,
  input  logic signed [31:0]   x2_i,
  input  logic [2:0]           xv_i,
  input  logic [4:0]           conv_shift_i,
  input  logic [4:0]           norm_shift_i,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o,
  output logic signed [31:0]   value_o
);

  logic signed [31:0] tap_mem  [Channels*Taps];
  logic signed [31:0] chan_mem [Channels*Kinds];

  logic signed [31:0] w_q, p_q;        // registered table reads
  logic signed [31:0] x_q [3];
  logic [2:0]         xv_q;
  logic signed [65:0] acc_q, acc_d;
  logic signed [31:0] conv_q, xn_q, bn_q, neg_q;
  logic signed [63:0] prod_q;
  logic               done_q;
  logic [3:0]         op_q;            // op whose reads are registered

  // table writes and registered reads
  logic [TapAddrW-1:0]  ta;
  logic [ChanAddrW-1:0] ca;
  logic [1:0]           nk;            // next tap needed
  always_comb begin
    nk = 2'd0;
    case (cmd_i.op)
      OP_TAP1:  nk = 2'd1;
      OP_TAP2:  nk = 2'd2;
      default:  nk = 2'd0;
    endcase
  end
  assign ta = TapAddrW'(32'(cmd_i.ch) * Taps + 32'(nk));
  logic [3:0] ck;
  always_comb begin
    ck = 4'd0;
    case (cmd_i.op)
      OP_CONV:  ck = 4'd0;  // bias
      OP_NORM:  ck = 4'd1;  // mean
      OP_NWRAP: ck = 4'd2;  // var
      OP_GAIN:  ck = 4'd3;  // gain
      OP_ACT:   ck = 4'd4;  // nbias
      OP_AFF:   ck = 4'd5;  // slope
      OP_OUT:   ck = 4'd6;  // affine gain
      default:  ck = 4'd0;
    endcase
  end
  logic [3:0] ckk;
  logic [ChanAddrW-1:0] ca2;
  assign ca  = ChanAddrW'(32'(cmd_i.ch) * Kinds + 32'(ck));
  assign ckk = ld_i ? kind_i : 4'd0;
  assign ca2 = ChanAddrW'(32'(ld_ch_i) * Kinds + 32'(ckk - 4'd3));

  always_ff @(posedge clk_i) begin
    if (ld_i && kind_i <= KindTapMax)
      tap_mem[TapAddrW'(32'(ld_ch_i) * Taps + 32'(kind_i))] <= ld_val_i;
    if (ld_i && kind_i > KindTapMax) chan_mem[ca2] <= ld_val_i;
    w_q <= tap_mem[ta];
    p_q <= chan_mem[ca];
  end

  // affine bias on a second read port
  logic signed [31:0] ab_q;
  logic [ChanAddrW-1:0] cab;
  assign cab = ChanAddrW'(32'(cmd_i.ch) * Kinds + 7);
  always_ff @(posedge clk_i) begin
    ab_q <= chan_mem[cab];
  end

  logic signed [63:0] mul_r;
  logic signed [31:0] ma, mb;
  always_comb begin
    ma = '0; mb = '0;
    case (op_q)
      OP_TAP0:  begin ma = x_q[0]; mb = w_q; end
      OP_TAP1:  begin ma = x_q[1]; mb = w_q; end
      OP_TAP2:  begin ma = x_q[2]; mb = w_q; end
      OP_GAIN:  begin ma = xn_q;   mb = p_q; end
      OP_AFF:   begin ma = bn_q;   mb = p_q; end
      OP_OUT:   begin ma = bn_q;   mb = p_q; end
      default:  ;
    endcase
    mul_r = ma * mb;
  end

  logic signed [32:0] d33;
  logic signed [32:0] dreg_q;
  logic signed [31:0] conv_d;
  assign d33 = 33'(conv_q) - 33'(p_q);

  always_comb begin
    acc_d = acc_q;
    conv_d = conv_q;
    case (op_q)
      OP_TAP0:  acc_d = xv_q[0] ? rshift(66'(mul_r), conv_shift_i) : '0;
      OP_TAP1:  acc_d = acc_q + (xv_q[1] ? rshift(66'(mul_r), conv_shift_i) : '0);
      OP_TAP2:  acc_d = acc_q + (xv_q[2] ? rshift(66'(mul_r), conv_shift_i) : '0);
      OP_CONV:  conv_d = sat32(66'(p_q) + acc_q);
      default:  ;
    endcase
  end

  // var multiply: 33 by 32 bits on the registered difference
  logic signed [64:0] dvp;
  logic signed [65:0] dv;
  assign dvp = dreg_q * p_q;
  assign dv  = rshift(66'(dvp), norm_shift_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q   <= OP_IDLE;
      done_q <= 1'b0;
      xv_q   <= '0;
    end else begin
      op_q   <= cmd_i.op;
      done_q <= (op_q == OP_OUT);
      if (cmd_i.start) xv_q <= xv_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      x_q[0] <= x0_i; x_q[1] <= x1_i; x_q[2] <= x2_i;
    end
    acc_q  <= acc_d;
    conv_q <= conv_d;
    prod_q <= mul_r;
    case (op_q)
      OP_NORM:  dreg_q <= d33;
      OP_NWRAP: xn_q   <= dv[31:0];
      OP_ACT:   bn_q   <= sat32(((66'(prod_q) + 66'sd8192) >>> 14) + 66'(p_q));
      OP_AFF:   neg_q  <= (bn_q < 0) ? 32'(((66'(mul_r) + 66'sd4096) >>> 13)) : bn_q;
      default:  ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (op_q == OP_OUT)
      value_o <= sat32(((66'(mul_r) + 66'sd4096) >>> 13) + 66'(ab_q) + 66'(neg_q));
  end
  assign sts_o.done = done_q;

endmodule

>>> hdl/cbp_ctrl.sv
// ----------------------------------------------------------------------------
// cbp_ctrl
// Sequencer: input handshake, row tracking, per-channel step schedule, output.
// ----------------------------------------------------------------------------
module cbp_ctrl import cbp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  cbp_in_if.sink      in_if,
  cbp_out_if.source   out_if,
  output logic        ld_o,
  output logic signed [31:0] x0_o,
  output logic signed [31:0] x1_o,
  output logic signed [31:0] x2_o,
  output logic [2:0]  xv_o,
  output cmd_t        cmd_o,
  input  sts_t        sts_i,
  input  logic signed [31:0] value_i
);
`include "conv_bn_prelu_fixed_point_macros.svh"

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RUN  = 4'b0010,
    S_WAIT = 4'b0100,
    S_OUT  = 4'b1000
  } state_e;

  state_e              state_q, state_d;
  logic [RowPosW-1:0]  rp_q;
  logic signed [31:0]  h0_q, h1_q;
  logic [ChW-1:0]      ch_q;
  logic [PosW-1:0]     pos_q;
  op_e                 op_q;
  logic                ovalid_q;
  logic [ChW-1:0]      och_q;
  logic                olast_q;
  logic signed [31:0]  oval_q;

  logic acc, odd, last, emit;
  assign in_if.ready = (state_q == S_IDLE);
  assign acc  = in_if.valid && in_if.ready;
  assign odd  = rp_q[0];
  assign last = (32'(rp_q) >= RowWidth - 1);
  assign emit = acc && (in_if.action != ActLoad) && (odd || last);
  assign ld_o = acc && (in_if.action == ActLoad) && (32'(in_if.channel_index) < Channels)
                && (in_if.param_kind <= KindLast);

  always_comb begin
    x0_o = odd ? h1_q : h0_q;
    x1_o = odd ? h0_q : in_if.data_value;
    x2_o = odd ? in_if.data_value : '0;
    xv_o = odd ? {2'b11, rp_q >= 8'd2} : {2'b01, rp_q >= 8'd1};
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (emit) state_d = S_RUN;
      S_RUN:  if (op_q == OP_OUT) state_d = S_WAIT;
      S_WAIT: if (sts_i.done) state_d = S_OUT;
      S_OUT:  if (out_if.ready)
                state_d = (32'(ch_q) == Channels - 1) ? S_IDLE : S_RUN;
      default: state_d = S_IDLE;
    endcase
  end

  assign cmd_o.start = emit;
  assign cmd_o.op    = (state_q == S_RUN) ? op_q : (emit ? OP_TAP0 : OP_IDLE);
  assign cmd_o.ch    = emit ? '0 : ch_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rp_q    <= '0;
      h0_q    <= '0;
      h1_q    <= '0;
      ch_q    <= '0;
      op_q    <= OP_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (acc && in_if.action != ActLoad) begin
        if (last) begin
          rp_q <= '0; h0_q <= '0; h1_q <= '0;
        end else begin
          rp_q <= rp_q + 8'd1; h1_q <= h0_q; h0_q <= in_if.data_value;
        end
      end
      if (emit) begin
        ch_q <= '0;
        op_q <= OP_TAP1;
      end else if (state_q == S_RUN && op_q != OP_OUT) begin
        op_q <= op_e'(op_q + 4'd1);
      end else if (state_q == S_OUT && out_if.ready) begin
        ch_q <= ch_q + 4'd1;
        op_q <= OP_TAP0;
      end
      if (sts_i.done) ovalid_q <= 1'b1;
      else if (out_if.ready) ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) pos_q <= PosW'(rp_q >> 1);
    if (sts_i.done) begin
      och_q   <= ch_q;
      olast_q <= (32'(ch_q) == Channels - 1);
      oval_q  <= value_i;
    end
  end

  assign out_if.valid        = ovalid_q;
  assign out_if.out_channel  = och_q;
  assign out_if.out_position = pos_q;
  assign out_if.out_value    = oval_q;
  assign out_if.last_of_run  = olast_q;

  `CBP_ASSERT_IMP(a_busy_no_ready, clk_i, rst_ni, state_q != S_IDLE, !in_if.ready)
  `CBP_ASSERT_IMP(a_valid_in_out, clk_i, rst_ni, out_if.valid, state_q == S_OUT)
  `CBP_ASSERT_NEXT(a_emit_run, clk_i, rst_ni, emit, state_q == S_RUN)

endmodule

>>> hdl/conv_bn_prelu_fixed_point.sv
// ----------------------------------------------------------------------------
// conv_bn_prelu_fixed_point
// Stride-2 three-tap convolution, batch norm and PReLU on a sample stream.
// ----------------------------------------------------------------------------
// Parameter loads and samples that complete no output position leave the
// block ready for the next word. A sample that completes an output position
// yields 12 results, one per channel, computed one channel at a time on a
// shared multiplier: for each channel the sequencer issues ten datapath steps,
// hands the value over and offers it at the output. The next word is accepted
// only after the last result is taken, and waits while the sink holds ready low.
module conv_bn_prelu_fixed_point import cbp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [4:0]  cfg_data_i,
  cbp_in_if.sink      in_if,
  cbp_out_if.source   out_if
);

  logic [4:0] conv_shift_q, norm_shift_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conv_shift_q <= 5'd14;
      norm_shift_q <= 5'd11;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CfgConvShift) conv_shift_q <= cfg_data_i;
      if (cfg_idx_i == CfgNormShift) norm_shift_q <= cfg_data_i;
    end
  end

  logic ld;
  logic signed [31:0] x0, x1, x2, val;
  logic [2:0] xv;
  cmd_t cmd;
  sts_t sts;

  cbp_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_if, .out_if, .ld_o(ld), .x0_o(x0), .x1_o(x1), .x2_o(x2),
    .xv_o(xv), .cmd_o(cmd), .sts_i(sts), .value_i(val)
  );

  cbp_datapath u_dp (
    .clk_i, .rst_ni, .ld_i(ld), .kind_i(in_if.param_kind),
    .ld_ch_i(in_if.channel_index), .ld_val_i(in_if.data_value),
    .x0_i(x0), .x1_i(x1), .x2_i(x2), .xv_i(xv),
    .conv_shift_i(conv_shift_q), .norm_shift_i(norm_shift_q),
    .cmd_i(cmd), .sts_o(sts), .value_o(val)
  );

endmodule

>>> test/tb_cbp_checker.sv
// ----------------------------------------------------------------------------
// tb_cbp_checker
// Watches the sample, result and register ports of the block. Predicts every
// channel value of each finished output position and compares the results
// in order.
// ----------------------------------------------------------------------------
module tb_cbp_checker import cbp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [4:0] cfg_data_i,
  cbp_in_if          in_mon,
  cbp_out_if         out_mon,
  output int         errors_o,
  output int         pending_o,
  output int         checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [95:0] wide_t;

  typedef struct {
    logic [3:0]         ch;
    logic [6:0]         pos;
    logic signed [31:0] value;
    logic               last;
  } act_word_t;

  act_word_t          act_q[$];
  logic [4:0]         conv_sh, norm_sh;
  logic signed [31:0] tap_w[Channels*Taps];
  logic signed [31:0] chan_p[Channels*Kinds];
  logic signed [31:0] prev0, prev1;
  int unsigned        row_idx;

  assign pending_o = act_q.size();

  function automatic wide_t round_sh(wide_t v, logic [4:0] s);
    if (s == 5'd0) return v;
    return (v + (wide_t'(1) <<< (s - 5'd1))) >>> s;
  endfunction

  function automatic logic signed [31:0] clamp32(wide_t v);
    if (v > wide_t'(32'sh7fffffff)) return 32'sh7fffffff;
    if (v < wide_t'(32'sh80000000)) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] prelu_value(int c, logic signed [31:0] x0,
      logic signed [31:0] x1, logic signed [31:0] x2, logic v0, logic v2);
    wide_t              acc, d, sc, ap;
    logic signed [31:0] conv, xn, bn, neg;
    int                 b;
    b   = c * Kinds;
    acc = round_sh(wide_t'(x1) * wide_t'(tap_w[c*Taps+1]), conv_sh);
    if (v0) acc += round_sh(wide_t'(x0) * wide_t'(tap_w[c*Taps]), conv_sh);
    if (v2) acc += round_sh(wide_t'(x2) * wide_t'(tap_w[c*Taps+2]), conv_sh);
    conv = clamp32(wide_t'(chan_p[b]) + acc);
    d    = wide_t'(conv) - wide_t'(chan_p[b+1]);
    xn   = 32'(round_sh(d * wide_t'(chan_p[b+2]), norm_sh));
    sc   = (wide_t'(xn) * wide_t'(chan_p[b+3]) + 8192) >>> 14;
    bn   = clamp32(sc + wide_t'(chan_p[b+4]));
    neg  = bn;
    if (bn < 0) neg = 32'((wide_t'(bn) * wide_t'(chan_p[b+5]) + 4096) >>> 13);
    ap   = (wide_t'(bn) * wide_t'(chan_p[b+6]) + 4096) >>> 13;
    return clamp32(ap + wide_t'(chan_p[b+7]) + wide_t'(neg));
  endfunction

  task automatic report(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    errors_o++;
  endtask

  task automatic take_sample(logic signed [31:0] val);
    logic      row_end, emit;
    act_word_t w;
    row_end = (row_idx >= RowWidth - 1);
    emit    = row_idx[0] || row_end;
    if (emit) begin
      for (int c = 0; c < Channels; c++) begin
        w.ch   = 4'(c);
        w.last = (c == Channels - 1);
        if (row_idx[0]) begin
          w.pos   = 7'((row_idx - 1) / 2);
          w.value = prelu_value(c, prev1, prev0, val, row_idx >= 2, 1'b1);
        end else begin
          w.pos   = 7'(row_idx / 2);
          w.value = prelu_value(c, prev0, val, 32'sd0, row_idx >= 1, 1'b0);
        end
        act_q.push_back(w);
      end
    end
    if (row_end) begin
      row_idx = 0;
      prev0   = '0;
      prev1   = '0;
    end else begin
      row_idx++;
      prev1 = prev0;
      prev0 = val;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    act_word_t w;
    if (!rst_ni) begin
      act_q.delete();
      conv_sh  = 5'd14;
      norm_sh  = 5'd11;
      prev0    = '0;
      prev1    = '0;
      row_idx  = 0;
      errors_o = 0;
      checked_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgConvShift) conv_sh = cfg_data_i;
        else norm_sh = cfg_data_i;
      end
      if (out_mon.valid && out_mon.ready) begin
        checked_o++;
        if (act_q.size() == 0) begin
          report($sformatf("unexpected word ch %0d pos %0d",
                           out_mon.out_channel, out_mon.out_position));
        end else begin
          w = act_q.pop_front();
          if (out_mon.out_channel !== w.ch || out_mon.out_position !== w.pos ||
              out_mon.out_value !== w.value || out_mon.last_of_run !== w.last)
            report($sformatf("got ch %0d pos %0d val %0d last %0b, want %0d %0d %0d %0b",
                             out_mon.out_channel, out_mon.out_position,
                             out_mon.out_value, out_mon.last_of_run,
                             w.ch, w.pos, w.value, w.last));
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.action == ActLoad) begin
          if (in_mon.channel_index < Channels) begin
            if (in_mon.param_kind <= KindTapMax)
              tap_w[in_mon.channel_index*Taps + in_mon.param_kind] = in_mon.data_value;
            else if (in_mon.param_kind <= KindLast)
              chan_p[in_mon.channel_index*Kinds + in_mon.param_kind - Taps] =
                in_mon.data_value;
          end
        end else begin
          take_sample(in_mon.data_value);
        end
      end
    end
  end
endmodule

>>> test/tb_conv_bn_prelu_fixed_point.sv
// ----------------------------------------------------------------------------
// tb_conv_bn_prelu_fixed_point
// Loads every channel parameter, then streams row samples, parameter reloads
// and bad loads with random stalls on both sides under several shift
// settings. A checker beside the block predicts and compares each result.
// ----------------------------------------------------------------------------
module tb_conv_bn_prelu_fixed_point;
  import cbp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic       ActSample = ~ActLoad;
  localparam logic [3:0] KindVar   = 4'd5;
  localparam logic [3:0] KindBad   = 4'd15;
  localparam int         Limit     = 600000;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic       cfg_idx_i = CfgConvShift;
  logic [4:0] cfg_data_i = '0;
  logic       quiet = 1'b0;
  int         errors, pending, checked, cycles;
  int         n_samples, n_loads;

  cbp_in_if  in_if ();
  cbp_out_if out_if ();

  conv_bn_prelu_fixed_point dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_if (in_if.sink), .out_if (out_if.source)
  );

  tb_cbp_checker u_chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_mon (in_if), .out_mon (out_if),
    .errors_o (errors), .pending_o (pending), .checked_o (checked)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    in_if.valid = 1'b0;
    in_if.action = ActLoad;
    in_if.param_kind = '0;
    in_if.channel_index = '0;
    in_if.data_value = '0;
    out_if.ready = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > Limit) begin
      $display("timeout after %0d cycles", cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  int stall_left = 0;
  always @(posedge clk_i) begin
    if (quiet) begin
      out_if.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_if.ready <= (stall_left == 0);
    end else if ($urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(1, 6);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  function automatic logic signed [31:0] edge_or_rand();
    case ($urandom_range(0, 7))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 32'sd0;
      3: return -32'sd1;
      4: return $signed(32'($urandom_range(0, 65535)) - 32'sd32768);
      default: return $urandom;
    endcase
  endfunction

  task automatic send(logic act, logic [3:0] kind, logic [3:0] ch,
                      logic signed [31:0] val);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_if.valid         <= 1'b1;
    in_if.action        <= act;
    in_if.param_kind    <= kind;
    in_if.channel_index <= ch;
    in_if.data_value    <= val;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    if (act == ActLoad) n_loads++;
    else n_samples++;
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic set_shifts(logic [4:0] cs, logic [4:0] ns);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CfgConvShift;
    cfg_data_i <= cs;
    @(posedge clk_i);
    cfg_idx_i  <= CfgNormShift;
    cfg_data_i <= ns;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic random_traffic(int count);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 80)
        send(ActSample, 4'($urandom), 4'($urandom), edge_or_rand());
      else if (r < 95)
        send(ActLoad, 4'($urandom_range(0, KindLast)),
             4'($urandom_range(0, Channels - 1)), edge_or_rand());
      else
        send(ActLoad, 4'($urandom_range(KindLast + 1, KindBad)),
             4'($urandom_range(Channels, 15)), $urandom);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_shifts(5'd1, 5'd1);
    for (int c = 0; c < Channels; c++)
      for (int k = 0; k <= KindLast; k++)
        send(ActLoad, 4'(k), 4'(c), edge_or_rand());
    send(ActLoad, KindBad, 4'd0, 32'sh7fffffff);
    send(ActLoad, KindVar, 4'd15, 32'sh80000000);
    send(ActLoad, 4'd11, 4'd12, -32'sd1);
    send(ActSample, KindBad, 4'd15, 32'sh7fffffff);
    send(ActSample, '0, '0, 32'sh80000000);
    send(ActSample, '0, '0, 32'sh7fffffff);
    send(ActSample, '0, '0, 32'sh80000000);
    send(ActSample, '0, '0, -32'sd1);
    send(ActSample, '0, '0, 32'sd0);
    drain();

    set_shifts(5'd31, 5'd31);
    random_traffic(25);
    drain();

    set_shifts(5'($urandom_range(1, 31)), 5'($urandom_range(1, 31)));
    random_traffic(25);
    drain();

    set_shifts(5'd14, 5'd11);
    quiet <= 1'b1;
    random_traffic(30);
    drain();

    $display("sent %0d samples and %0d parameter loads, checked %0d results",
             n_samples, n_loads, checked);
    $display("shift settings covered: 1/1, 31/31, random, 14/11 without idling");
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
